[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros shared by the ellipse tessellator modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define EOT_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define EOT_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/eot_pkg.sv]
// ----------------------------------------------------------------------------
// eot_pkg
// types, widths and helper functions for the ellipse outline tessellator
// ----------------------------------------------------------------------------
package eot_pkg;

   localparam int SEGMENTS_DEFAULT = 10;
   localparam int QUEUE_DEPTH      = 2;

   localparam int COORD_W = 32;
   localparam int NEG_W   = COORD_W + 1;      // negated axis, exact
   localparam int COEF_W  = 18;               // signed Q1.16 coefficient
   localparam int PROD_W  = COORD_W + COEF_W; // one axis times one coefficient
   localparam int SUM_W   = PROD_W + 1;
   localparam int FRAC_W  = 16;
   localparam int PT_W    = SUM_W - FRAC_W;   // rounded outline point
   localparam int END_W   = PT_W + 1;         // center plus or minus point

   typedef logic signed [COORD_W-1:0] eot_coord_type;
   typedef logic signed [NEG_W-1:0]   eot_neg_type;
   typedef logic signed [PT_W-1:0]    eot_point_type;

   typedef struct packed {
      eot_coord_type center_x;
      eot_coord_type center_y;
      eot_coord_type center_z;
      eot_coord_type major_x;
      eot_coord_type major_y;
      eot_coord_type major_z;
      eot_coord_type minor_x;
      eot_coord_type minor_y;
      eot_coord_type minor_z;
   } eot_req_type;

   typedef struct packed {
      eot_coord_type start_x;
      eot_coord_type start_y;
      eot_coord_type start_z;
      eot_coord_type end_x;
      eot_coord_type end_y;
      eot_coord_type end_z;
      logic          last_segment;
   } eot_rsp_type;

   // one ellipse as queued between front and back, per-axis lanes x, y, z
   typedef struct packed {
      eot_coord_type [2:0] center;
      eot_coord_type [2:0] major;
      eot_coord_type [2:0] minor;
      eot_neg_type   [2:0] neg_major;
   } eot_job_type;

   // integer square root, used for the coefficient table at elaboration
   function automatic logic [63:0] isqrt64(input logic [63:0] x_arg);
      logic [63:0] x;
      logic [63:0] r;
      logic [63:0] b;
      x = x_arg;
      r = '0;
      b = 64'h4000_0000_0000_0000;
      for (int s = 0; s < 32; s++) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // clamp to the signed 32-bit range
   function automatic eot_coord_type sat32(input logic signed [END_W-1:0] v);
      eot_coord_type res;
      if ((&v[END_W-1:COORD_W-1]) || !(|v[END_W-1:COORD_W-1])) begin
         res = v[COORD_W-1:0];
      end else if (v[END_W-1]) begin
         res = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         res = {1'b0, {(COORD_W-1){1'b1}}};
      end
      return res;
   endfunction

endpackage

[hdl/eot_front.sv]
// ----------------------------------------------------------------------------
// eot_front
// input register: takes an ellipse, splits it into lanes, forms -major
// ----------------------------------------------------------------------------
module eot_front import eot_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  eot_req_type req_data,
   output logic        push,
   output eot_job_type push_job,
   input  logic        full
);

   logic        valid_ff, valid_in;
   eot_job_type job_ff, job_in;
   logic        take;

   assign req_stall = valid_ff && full;
   assign take      = req_valid && !req_stall;
   assign push      = valid_ff && !full;
   assign push_job  = job_ff;

   always_comb begin
      job_in              = job_ff;
      job_in.center[0]    = req_data.center_x;
      job_in.center[1]    = req_data.center_y;
      job_in.center[2]    = req_data.center_z;
      job_in.major[0]     = req_data.major_x;
      job_in.major[1]     = req_data.major_y;
      job_in.major[2]     = req_data.major_z;
      job_in.minor[0]     = req_data.minor_x;
      job_in.minor[1]     = req_data.minor_y;
      job_in.minor[2]     = req_data.minor_z;
      // first outline point is the far end of the major axis
      job_in.neg_major[0] = -NEG_W'(req_data.major_x);
      job_in.neg_major[1] = -NEG_W'(req_data.major_y);
      job_in.neg_major[2] = -NEG_W'(req_data.major_z);
   end

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         job_ff <= job_in;
      end
   end

endmodule

[hdl/eot_queue.sv]
// ----------------------------------------------------------------------------
// eot_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module eot_queue import eot_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  eot_job_type push_job,
   output logic        full,
   output logic        head_valid,
   output eot_job_type head_job,
   input  logic        pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   eot_job_type      entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_job   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   `EOT_ASSERT_IMP(a_no_push_when_full, push, !full, "queue written while full")
   `EOT_ASSERT_IMP(a_no_pop_when_empty, pop, head_valid, "queue read while empty")
   `EOT_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= CNT_FULL, "queue count past depth")

endmodule

[hdl/eot_back.sv]
// ----------------------------------------------------------------------------
// eot_back
// outline sequencer: one segment per cycle unless the output stalls, multiply, round, offset, clamp
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module eot_back import eot_pkg::*; #(
   parameter int SEGMENTS = SEGMENTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  eot_job_type head_job,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output eot_rsp_type rsp_data
);

   localparam int K_W   = $clog2(SEGMENTS + 1);
   localparam int IDX_W = $clog2(SEGMENTS);
   localparam logic [K_W-1:0] K_LAST = K_W'(SEGMENTS);
   localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1 << (FRAC_W - 1));

   // coefficient table, px signed Q1.16 and py signed Q1.16 (never negative)
   logic signed [COEF_W-1:0] px_tab [SEGMENTS];
   logic signed [COEF_W-1:0] py_tab [SEGMENTS];

   for (genvar g = 0; g < SEGMENTS; g++) begin : gen_tab
      localparam longint D   = SEGMENTS + 1;
      localparam longint N   = 2 * (g + 1) - D;
      localparam longint NUM = N * 65536;
      localparam longint PXV = (NUM >= 0) ? (NUM + D / 2) / D : -((-NUM + D / 2) / D);
      localparam longint REM = ((D * D - N * N) * 64'sd4294967296) / (D * D);
      assign px_tab[g] = COEF_W'(PXV);
      assign py_tab[g] = COEF_W'(isqrt64(REM));
   end

   // sequencer
   logic [K_W-1:0] k_ff, k_in;
   logic           phase_ff, phase_in;   // 0 upper arc, 1 lower arc
   logic           advance;
   logic           issue;
   logic [IDX_W-1:0] idx;
   logic signed [COEF_W-1:0] px_sel, py_sel;

   // stage 1: products
   logic                     s1_valid_ff;
   logic                     s1_phase_ff, s1_first_ff, s1_top_ff;
   eot_coord_type            s1_center_ff [3];
   eot_coord_type            s1_major_ff  [3];
   eot_neg_type              s1_neg_ff    [3];
   logic signed [PROD_W-1:0] s1_pmaj_ff   [3];
   logic signed [PROD_W-1:0] s1_pmin_ff   [3];
   logic signed [PROD_W-1:0] pmaj_in      [3];
   logic signed [PROD_W-1:0] pmin_in      [3];

   // stage 2: previous and current outline points
   logic                    s2_valid_ff;
   logic                    s2_phase_ff, s2_last_ff;
   eot_coord_type           s2_center_ff [3];
   eot_point_type           prev_ff [3], prev_in [3];
   eot_point_type           cur_ff  [3], cur_in  [3];
   logic signed [SUM_W-1:0] sum     [3];

   // output register
   logic                    rsp_valid_ff;
   eot_rsp_type             rsp_data_ff, rsp_data_in;
   logic signed [END_W-1:0] st [3];
   logic signed [END_W-1:0] en [3];

   assign advance = !(rsp_valid_ff && rsp_stall);
   assign issue   = advance && head_valid;
   assign pop     = issue && phase_ff && (k_ff == K_LAST);

   always_comb begin
      k_in     = k_ff;
      phase_in = phase_ff;
      if (issue) begin
         phase_in = !phase_ff;
         if (phase_ff) begin
            k_in = (k_ff == K_LAST) ? '0 : k_ff + 1'b1;
         end
      end
   end

   assign idx    = (k_ff == K_LAST) ? '0 : k_ff[IDX_W-1:0];
   assign px_sel = px_tab[idx];
   assign py_sel = py_tab[idx];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         pmaj_in[j] = $signed(head_job.major[j]) * px_sel;
         pmin_in[j] = $signed(head_job.minor[j]) * py_sel;
      end
   end

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         sum[j]     = SUM_W'(s1_pmaj_ff[j]) + SUM_W'(s1_pmin_ff[j]) + ROUND_HALF;
         prev_in[j] = prev_ff[j];
         cur_in[j]  = cur_ff[j];
         // a new point enters on the upper-arc transfer only
         if (s1_valid_ff && !s1_phase_ff) begin
            prev_in[j] = s1_first_ff ? PT_W'(s1_neg_ff[j]) : cur_ff[j];
            cur_in[j]  = s1_top_ff ? PT_W'(s1_major_ff[j]) : sum[j][SUM_W-1:FRAC_W];
         end
      end
   end

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         st[j] = s2_phase_ff ? END_W'(s2_center_ff[j]) - END_W'(prev_ff[j])
                             : END_W'(s2_center_ff[j]) + END_W'(prev_ff[j]);
         en[j] = s2_phase_ff ? END_W'(s2_center_ff[j]) - END_W'(cur_ff[j])
                             : END_W'(s2_center_ff[j]) + END_W'(cur_ff[j]);
      end
      rsp_data_in.start_x      = sat32(st[0]);
      rsp_data_in.start_y      = sat32(st[1]);
      rsp_data_in.start_z      = sat32(st[2]);
      rsp_data_in.end_x        = sat32(en[0]);
      rsp_data_in.end_y        = sat32(en[1]);
      rsp_data_in.end_z        = sat32(en[2]);
      rsp_data_in.last_segment = s2_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff         <= '0;
         phase_ff     <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         k_ff     <= k_in;
         phase_ff <= phase_in;
         if (advance) begin
            s1_valid_ff  <= issue;
            s2_valid_ff  <= s1_valid_ff;
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_phase_ff <= phase_ff;
         s1_first_ff <= (k_ff == '0);
         s1_top_ff   <= (k_ff == K_LAST);
         for (int j = 0; j < 3; j++) begin
            s1_center_ff[j] <= head_job.center[j];
            s1_major_ff[j]  <= head_job.major[j];
            s1_neg_ff[j]    <= head_job.neg_major[j];
            s1_pmaj_ff[j]   <= pmaj_in[j];
            s1_pmin_ff[j]   <= pmin_in[j];
         end
         s2_phase_ff <= s1_phase_ff;
         s2_last_ff  <= s1_phase_ff && s1_top_ff;
         for (int j = 0; j < 3; j++) begin
            s2_center_ff[j] <= s1_center_ff[j];
            prev_ff[j]      <= prev_in[j];
            cur_ff[j]       <= cur_in[j];
         end
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // lower-arc transfer always trails its upper-arc partner by one stage
   `EOT_ASSERT_IMP(a_arc_pairing, s1_valid_ff && s1_phase_ff, s2_valid_ff && !s2_phase_ff,
                   "lower arc segment lost its upper arc partner")
   `EOT_ASSERT_NXT(a_seq_frozen, rsp_valid_ff && rsp_stall, $stable(k_ff) && $stable(phase_ff),
                   "sequencer moved while output stalled")

endmodule

[hdl/ellipse_outline_tessellator_top.sv]
// ----------------------------------------------------------------------------
// ellipse_outline_tessellator_top
// ellipse outline tessellator: one ellipse in, 2*(SEGMENTS+1) segments out
// ----------------------------------------------------------------------------
// Usage
//   req_*: one ellipse per transfer (center, major and minor semi-axis,
//   signed Q16.16). rsp_*: line segments in order, upper arc and lower arc
//   alternating, last_segment high on the closing lower segment.
//   A transfer happens on a rising clock edge with valid high and stall low.
// Path: the first segment of an ellipse passes the front register, the job
//   queue, stage 1, stage 2 and the output register of the back end.
// Throughput: one segment per cycle while the output is not stalled; the
//   back-end sequencer emitting one segment per cycle sets this. Front
//   register and a 2-entry job queue keep accepting ellipses while the
//   back end works, so runs follow without gaps.
// Reset: synchronous, clears all valid and sequencing state; the block holds
//   no results afterwards and is ready at once.
// Stall: rsp_stall freezes the whole back-end pipeline and holds the output
//   segment; req_stall rises once the front register and the queue are full.
// ----------------------------------------------------------------------------
module ellipse_outline_tessellator_top import eot_pkg::*; #(
   parameter int SEGMENTS = SEGMENTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  eot_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output eot_rsp_type rsp_data
);

   logic        push;
   eot_job_type push_job;
   logic        full;
   logic        head_valid;
   eot_job_type head_job;
   logic        pop;

   eot_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .push      (push),
      .push_job  (push_job),
      .full      (full)
   );

   eot_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (full),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop)
   );

   eot_back #(
      .SEGMENTS (SEGMENTS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
